@@ rtl/core/image_header_size_parser_unit_defines.svh @@
// assertion macros for the image header size parser
`ifndef IMAGE_HEADER_SIZE_PARSER_UNIT_DEFINES_SVH
`define IMAGE_HEADER_SIZE_PARSER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IHSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IHSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ihsp_pkg.sv @@
// types, codes and signature tables for the image header size parser
package ihsp_pkg;

    localparam logic [1:0] FMT_JPEG = 2'd0;
    localparam logic [1:0] FMT_PNG  = 2'd1;
    localparam logic [1:0] FMT_BMP  = 2'd2;

    localparam logic [4:0] POS_MAX = 5'd31;

    localparam logic [7:0] JPEG_MARK = 8'hFF;
    localparam logic [7:0] JPEG_SOF0 = 8'hC0;
    localparam logic [7:0] JPEG_SOF1 = 8'hC1;
    localparam logic [7:0] JPEG_SOF2 = 8'hC2;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_SKIP   = 3'd2,
        PH_HEIGHT = 3'd3,
        PH_WIDTH  = 3'd4
    } scan_phase_t;

    function automatic logic [7:0] jpeg_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'hFF;
            2'd1:    v = 8'hD8;
            2'd2:    v = 8'hFF;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] png_magic(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            3'd7:    v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] png_tag(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h48;
            2'd2:    v = 8'h44;
            2'd3:    v = 8'h52;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/image_header_size_parser_unit.sv @@
// image header size parser: width and height from a jpeg, png or bmp byte stream
//
//  channel | dir | handshake           | payload
//  s       | in  | s_tvalid / s_tready | s_tdata[7:0] data_byte, s_tlast last_byte
//  m       | out | m_tvalid / m_tready | m_tdata[31:0] image_width, [63:32] image_height
//  cfg     | in  | cfg_valid/cfg_ready | cfg_data[1:0] image_format
//
// one byte per cycle while s_tready is high; the parse state updates in the cycle a byte beat is taken
// the result beat appears in the cycle after the beat with s_tlast set
// s_tready drops only while a finished result waits on a stalled m_tready
// rst_n clears the parse state, the format register and the result valid
// cfg_ready is always high
`include "image_header_size_parser_unit_defines.svh"

module image_header_size_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] image_width, [63:32] image_height
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // [1:0] image_format
);
    import ihsp_pkg::*;

    logic [1:0]  fmt_reg;
    logic [4:0]  pos_reg,     pos_next;
    scan_phase_t phase_reg,   phase_next;
    logic [2:0]  cnt_reg,     cnt_next;
    logic [31:0] shift_reg,   shift_next;
    logic [15:0] hold_reg,    hold_next;
    logic [31:0] best_w_reg,  best_w_next;
    logic [31:0] best_h_reg,  best_h_next;
    logic        failed_reg,  failed_next;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;

    logic [7:0]  b;
    logic        accept;
    logic [31:0] jpeg_w;

    assign b         = s_tdata;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign jpeg_w    = {16'd0, shift_reg[7:0], b};

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        hold_next   = hold_reg;
        best_w_next = best_w_reg;
        best_h_next = best_h_reg;
        failed_next = failed_reg;
        if (!failed_reg)
        begin
            case (fmt_reg)
                FMT_JPEG:
                begin
                    if (pos_reg < 5'd4)
                    begin
                        if (pos_reg < 5'd3 && b != jpeg_magic(pos_reg[1:0]))
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_SEEK:
                            begin
                                if (b == JPEG_MARK)
                                begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE:
                            begin
                                if (b inside {JPEG_SOF0, JPEG_SOF1, JPEG_SOF2})
                                begin
                                    phase_next = PH_SKIP;
                                    cnt_next   = 3'd0;
                                end
                                else
                                begin
                                    phase_next = PH_SEEK;
                                end
                            end
                            PH_SKIP:
                            begin
                                cnt_next = cnt_reg + 3'd1;
                                if (cnt_reg + 3'd1 >= 3'd3)
                                begin
                                    phase_next = PH_HEIGHT;
                                    cnt_next   = 3'd0;
                                end
                            end
                            PH_HEIGHT:
                            begin
                                hold_next = {hold_reg[7:0], b};
                                cnt_next  = cnt_reg + 3'd1;
                                if (cnt_reg + 3'd1 >= 3'd2)
                                begin
                                    phase_next = PH_WIDTH;
                                    cnt_next   = 3'd0;
                                end
                            end
                            PH_WIDTH:
                            begin
                                shift_next = jpeg_w;
                                cnt_next   = cnt_reg + 3'd1;
                                if (cnt_reg + 3'd1 >= 3'd2)
                                begin
                                    if (jpeg_w > best_w_reg || {16'd0, hold_reg} > best_h_reg)
                                    begin
                                        best_w_next = jpeg_w;
                                        best_h_next = {16'd0, hold_reg};
                                    end
                                    phase_next = PH_SEEK;
                                    cnt_next   = 3'd0;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_SEEK;
                                cnt_next   = 3'd0;
                            end
                        endcase
                    end
                end
                FMT_PNG:
                begin
                    if (pos_reg < 5'd8)
                    begin
                        if (b != png_magic(pos_reg[2:0]))
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (pos_reg inside {[5'd12:5'd15]})
                    begin
                        if (b != png_tag(pos_reg[1:0]))
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (pos_reg inside {[5'd16:5'd23]})
                    begin
                        shift_next = {shift_reg[23:0], b};
                        if (pos_reg == 5'd19)
                        begin
                            best_w_next = {shift_reg[23:0], b};
                        end
                        if (pos_reg == 5'd23)
                        begin
                            best_h_next = {shift_reg[23:0], b};
                        end
                    end
                end
                FMT_BMP:
                begin
                    if (pos_reg inside {[5'd18:5'd25]})
                    begin
                        shift_next = {b, shift_reg[31:8]};
                        if (pos_reg == 5'd21)
                        begin
                            best_w_next = {b, shift_reg[31:8]};
                        end
                        if (pos_reg == 5'd25)
                        begin
                            best_h_next = {b, shift_reg[31:8]};
                        end
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    // parse state, cleared after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 5'd0;
            phase_reg  <= PH_SEEK;
            cnt_reg    <= 3'd0;
            shift_reg  <= 32'd0;
            hold_reg   <= 16'd0;
            best_w_reg <= 32'd0;
            best_h_reg <= 32'd0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                pos_reg    <= 5'd0;
                phase_reg  <= PH_SEEK;
                cnt_reg    <= 3'd0;
                shift_reg  <= 32'd0;
                hold_reg   <= 16'd0;
                best_w_reg <= 32'd0;
                best_h_reg <= 32'd0;
                failed_reg <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                shift_reg  <= shift_next;
                hold_reg   <= hold_next;
                best_w_reg <= best_w_next;
                best_h_reg <= best_h_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_JPEG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= cfg_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept && s_tlast)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            m_data_reg <= failed_next ? 64'd0 : {best_h_next, best_w_next};
        end
    end

    `IHSP_ASSERT_NEXT(a_last_gives_beat, accept && s_tlast, m_valid_reg, "no result after last beat")
    `IHSP_ASSERT_NEXT(a_failed_gives_zero, accept && s_tlast && failed_reg, m_data_reg == 64'd0, "failed header gave nonzero size")
    `IHSP_ASSERT_NEXT(a_last_clears, accept && s_tlast, pos_reg == 5'd0 && !failed_reg && phase_reg == PH_SEEK, "state not cleared after last beat")
    `IHSP_ASSERT_NEXT(a_pos_saturates, accept && !s_tlast && pos_reg == POS_MAX, pos_reg == POS_MAX, "byte position wrapped")
    `IHSP_ASSERT_SAME(a_stall_blocks_input, m_valid_reg && !m_tready, !s_tready, "input taken while result stalled")

endmodule

@@ bench/tb_image_header_size_parser_unit.sv @@
// testbench for the image header size parser unit: file bytes in, checked width and height out
module tb_image_header_size_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ihsp_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RUN_LIMIT   = 200000;
    localparam int BYTE_TARGET = 540;
    localparam int FILE_TARGET = 24;

    localparam logic [1:0]  FMT_NONE = 2'd3;
    localparam logic [23:0] JPEG_SIG = 24'hFFD8FF;
    localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
    localparam logic [31:0] PNG_IHDR = 32'h49484452;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        logic [31:0] height;
        logic [31:0] width;
    } dims_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;

    image_header_size_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    byte_beat_t  byte_feed_q[$];
    dims_t       dims_due_q[$];
    logic [7:0]  file_q[$];

    logic        s_taken   = 1'b0;
    logic        cfg_taken = 1'b0;
    int          src_gap, snk_gap;
    int          src_idle_pct, snk_idle_pct;
    int          cycles, bytes_queued, bytes_taken, files_sent;
    int          dims_checked, mismatches, fmt_writes;

    // parser copy
    logic [1:0]  fmt_reg;
    logic [4:0]  hdr_pos;
    scan_phase_t sof_phase;
    logic [2:0]  sof_cnt;
    logic [31:0] shift_acc;
    logic [15:0] sof_height;
    logic [31:0] keep_w, keep_h;
    logic        hdr_bad;

    function automatic void clear_parse();
        hdr_pos    = '0;
        sof_phase  = PH_SEEK;
        sof_cnt    = '0;
        shift_acc  = '0;
        sof_height = '0;
        keep_w     = '0;
        keep_h     = '0;
        hdr_bad    = 1'b0;
    endfunction

    function automatic void take_jpeg(input logic [7:0] b);
        int p;
        p = hdr_pos;
        if (p < 4) begin
            if (p < 3 && b != JPEG_SIG[8 * (2 - p) +: 8])
                hdr_bad = 1'b1;
        end
        else begin
            case (sof_phase)
                PH_SEEK:
                    if (b == JPEG_MARK)
                        sof_phase = PH_TYPE;
                PH_TYPE:
                    if (b == JPEG_SOF0 || b == JPEG_SOF1 || b == JPEG_SOF2)
                    begin
                        sof_phase = PH_SKIP;
                        sof_cnt   = '0;
                    end
                    else
                        sof_phase = PH_SEEK;
                PH_SKIP:
                begin
                    sof_cnt = sof_cnt + 3'd1;
                    if (sof_cnt >= 3'd3)
                    begin
                        sof_phase = PH_HEIGHT;
                        sof_cnt   = '0;
                    end
                end
                PH_HEIGHT:
                begin
                    sof_height = {sof_height[7:0], b};
                    sof_cnt    = sof_cnt + 3'd1;
                    if (sof_cnt >= 3'd2)
                    begin
                        sof_phase = PH_WIDTH;
                        sof_cnt   = '0;
                    end
                end
                PH_WIDTH:
                begin
                    shift_acc = {16'h0, shift_acc[7:0], b};
                    sof_cnt   = sof_cnt + 3'd1;
                    if (sof_cnt >= 3'd2)
                    begin
                        // a frame wins if either dimension beats the kept one
                        if (shift_acc > keep_w || {16'h0, sof_height} > keep_h)
                        begin
                            keep_w = shift_acc;
                            keep_h = {16'h0, sof_height};
                        end
                        sof_phase = PH_SEEK;
                        sof_cnt   = '0;
                    end
                end
                default:
                begin
                    sof_phase = PH_SEEK;
                    sof_cnt   = '0;
                end
            endcase
        end
    endfunction

    function automatic void take_png(input logic [7:0] b);
        int p;
        p = hdr_pos;
        if (p < 8) begin
            if (b != PNG_SIG[8 * (7 - p) +: 8])
                hdr_bad = 1'b1;
        end
        else if (p >= 12 && p < 16) begin
            if (b != PNG_IHDR[8 * (15 - p) +: 8])
                hdr_bad = 1'b1;
        end
        else if (p >= 16 && p < 24) begin
            shift_acc = {shift_acc[23:0], b};
            if (p == 19)
                keep_w = shift_acc;
            if (p == 23)
                keep_h = shift_acc;
        end
    endfunction

    function automatic void take_bmp(input logic [7:0] b);
        int p;
        p = hdr_pos;
        if (p >= 18 && p < 26) begin
            shift_acc = {b, shift_acc[31:8]};
            if (p == 21)
                keep_w = shift_acc;
            if (p == 25)
                keep_h = shift_acc;
        end
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output dims_t res);
        res = '0;
        if (!hdr_bad) begin
            case (fmt_reg)
                FMT_JPEG: take_jpeg(b);
                FMT_PNG:  take_png(b);
                FMT_BMP:  take_bmp(b);
                default:  hdr_bad = 1'b1;
            endcase
        end
        if (hdr_pos != POS_MAX)
            hdr_pos = hdr_pos + 5'd1;
        if (!last)
            return 1'b0;
        res.width  = hdr_bad ? '0 : keep_w;
        res.height = hdr_bad ? '0 : keep_h;
        clear_parse();
        return 1'b1;
    endfunction

    // file builders
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            file_q.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void add_le(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_q.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void add_noise(input int n);
        repeat (n)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void add_sof();
        file_q.push_back(JPEG_MARK);
        file_q.push_back(JPEG_SOF0 + 8'($urandom_range(0, 2)));
        add_noise(3);
        add_be(pick_word(), 2);
        add_be(pick_word(), 2);
    endfunction

    function automatic void make_jpeg();
        add_be({8'h0, JPEG_SIG}, 3);
        add_noise(1);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: add_sof();
                3:       add_noise($urandom_range(1, 6));
                4:
                begin
                    // marker right after a marker: the second one is the type byte
                    file_q.push_back(JPEG_MARK);
                    add_sof();
                end
                default:
                begin
                    file_q.push_back(JPEG_MARK);
                    add_noise(1);
                end
            endcase
        end
    endfunction

    function automatic void make_png();
        add_be(PNG_SIG[63:32], 4);
        add_be(PNG_SIG[31:0], 4);
        add_noise(4);
        add_be(PNG_IHDR, 4);
        add_be(pick_word(), 4);
        add_be(pick_word(), 4);
        add_noise($urandom_range(0, 4));
    endfunction

    function automatic void make_bmp();
        add_noise(18);
        add_le(pick_word());
        add_le(pick_word());
        add_noise($urandom_range(0, 10));
    endfunction

    function automatic void make_file(input logic [1:0] fmt);
        int cut;
        file_q.delete();
        if ($urandom_range(0, 9) == 0)
            add_noise($urandom_range(1, 12));
        else begin
            case (fmt)
                FMT_JPEG: make_jpeg();
                FMT_PNG:  make_png();
                FMT_BMP:  make_bmp();
                default:  add_noise($urandom_range(1, 12));
            endcase
        end
        // broken header
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, file_q.size() > 16 ? 15 : file_q.size() - 1);
            file_q[cut] = file_q[cut] ^ 8'($urandom_range(1, 255));
        end
        // file cut short
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut)
                void'(file_q.pop_back());
        end
    endfunction

    function automatic void queue_bytes(input int first, input int upto, input bit with_last);
        byte_beat_t nb;
        for (int i = first; i < upto; i++) begin
            nb.data = file_q[i];
            nb.last = with_last && (i == upto - 1);
            byte_feed_q.push_back(nb);
            bytes_queued++;
        end
        if (with_last)
            files_sent++;
    endfunction

    function automatic logic [1:0] pick_format();
        case ($urandom_range(0, 9))
            0, 1, 2: return FMT_JPEG;
            3, 4, 5: return FMT_PNG;
            6, 7, 8: return FMT_BMP;
            default: return FMT_NONE;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    task automatic settle();
        while (bytes_taken != bytes_queued || dims_due_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_format(input logic [1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
        fmt_writes++;
    endtask

    // byte driver
    always @(negedge clk)
    begin
        byte_beat_t nb;
        if (rst_n && (!s_tvalid || s_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nb = byte_feed_q.pop_front();
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
                s_tvalid <= 1'b1;
            end
            else begin
                if (byte_feed_q.size() != 0)
                    src_gap = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < snk_idle_pct) begin
            snk_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        dims_t due, seen;
        s_taken   <= s_tvalid && s_tready;
        cfg_taken <= cfg_valid && cfg_ready;
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("tb_image_header_size_parser_unit failed");
            $finish;
        end
        else if (rst_n) begin
            if (cfg_valid && cfg_ready)
                fmt_reg = cfg_data;
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (dims_due_q.size() == 0) begin
                    $error("result beat with nothing due: width %0h height %0h",
                           seen.width, seen.height);
                    mismatches++;
                end
                else begin
                    due = dims_due_q.pop_front();
                    dims_checked++;
                    if (seen.width !== due.width) begin
                        $error("image_width expected %0h got %0h", due.width, seen.width);
                        mismatches++;
                    end
                    if (seen.height !== due.height) begin
                        $error("image_height expected %0h got %0h", due.height, seen.height);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (parse_byte(s_tdata, s_tlast, due))
                    dims_due_q.push_back(due);
            end
        end
    end

    initial
    begin
        logic [1:0] fmt;
        int         cut;
        fmt_reg = FMT_JPEG;
        clear_parse();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: largest jpeg frame, one-byte file, unused format code
        write_format(FMT_JPEG);
        file_q = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'hFF, 8'hC0, 8'h11, 8'h22, 8'h33,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_bytes(0, file_q.size(), 1'b1);
        file_q = {8'h00};
        queue_bytes(0, 1, 1'b1);
        settle();
        write_format(FMT_NONE);
        file_q = {8'h00, 8'hFF};
        queue_bytes(0, 2, 1'b1);
        settle();

        while (bytes_queued < BYTE_TARGET || files_sent < FILE_TARGET) begin
            fmt = pick_format();
            src_idle_pct = pick_pct();
            snk_idle_pct = pick_pct();
            write_format(fmt);
            repeat ($urandom_range(1, 4)) begin
                make_file(fmt);
                queue_bytes(0, file_q.size(), 1'b1);
            end
            // format switched with a file half read
            if ($urandom_range(0, 4) == 0) begin
                make_file(fmt);
                if (file_q.size() > 1) begin
                    cut = $urandom_range(1, file_q.size() - 1);
                    queue_bytes(0, cut, 1'b0);
                    settle();
                    write_format(pick_format());
                    queue_bytes(cut, file_q.size(), 1'b1);
                end
            end
            settle();
        end

        // closing stretch at full rate
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_format(FMT_BMP);
        repeat (2) begin
            make_file(FMT_BMP);
            queue_bytes(0, file_q.size(), 1'b1);
        end
        settle();

        $display("checked %0d size results from %0d files, %0d bytes in total",
                 dims_checked, files_sent, bytes_taken);
        $display("format register written %0d times incl. mid-file switches and code 3",
                 fmt_writes);
        if (mismatches == 0)
            $display("tb_image_header_size_parser_unit passed");
        else
            $display("tb_image_header_size_parser_unit failed");
        $finish;
    end

endmodule

@@ image_header_size_parser_unit.f @@
+incdir+rtl/core
rtl/core/ihsp_pkg.sv
rtl/core/image_header_size_parser_unit.sv
bench/tb_image_header_size_parser_unit.sv
